// ===== hdl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
`default_nettype none

package ffba_pkg;

    // Table geometry and block layout.
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 8;
    localparam int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    // Field widths.
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 24;
    localparam int HEAP_SIZE_W = 25;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // The largest offset the walk can reach: every block full size.
    localparam longint unsigned OFF_MAX =
        longint'(MAX_BLOCKS) * (longint'(HEADER_BYTES) + (longint'(1) << SIZE_W));
    localparam int OFF_W = $clog2(OFF_MAX + 1);
    localparam int CMP_W = ((OFF_W > HEAP_SIZE_W) ? OFF_W : HEAP_SIZE_W) + 1;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic walk_end;
        logic out_room;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/ffba_ctrl.sv =====
// Controller state machine of the first-fit block allocator.
// Drives the datapath through ffba_pkg::t_dp_cmd and reads ffba_pkg::t_dp_sts.
// Depends on ffba_pkg.
`default_nettype none

module ffba_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire ffba_pkg::t_dp_sts i_sts,
    output ffba_pkg::t_dp_cmd     o_cmd
);

    ffba_pkg::t_state r_state;
    ffba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ffba_pkg::S_WALK;
                end
            end
            ffba_pkg::S_WALK: begin
                if (i_sts.hit || i_sts.walk_end) begin
                    n_state = ffba_pkg::S_FINISH;
                end
            end
            ffba_pkg::S_FINISH: begin
                if (i_sts.out_room) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ffba_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
            end
            ffba_pkg::S_FINISH: begin
                o_cmd.finish = i_sts.out_room;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/ffba_dp.sv =====
// Datapath of the first-fit block allocator: block table, walk pipeline,
// configuration registers and the output register.
// Depends on ffba_pkg.
`default_nettype none

module ffba_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ffba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ffba_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_req_type,
    input  wire logic [ffba_pkg::SIZE_W-1:0]        i_request_size,
    input  wire logic [ffba_pkg::ADDR_W-1:0]        i_free_address,
    input  wire logic                               i_out_stall,
    output logic                                    o_out_valid,
    output logic [ffba_pkg::ADDR_W-1:0]             o_payload_address,
    output logic [ffba_pkg::STATUS_W-1:0]           o_status,
    input  wire ffba_pkg::t_dp_cmd                  i_cmd,
    output ffba_pkg::t_dp_sts                       o_sts
);

    // Configuration.
    logic [ffba_pkg::ADDR_W-1:0]       r_base;
    logic [ffba_pkg::HEAP_SIZE_W-1:0]  r_size;

    // Latched request.
    logic                              r_req_type;
    logic [ffba_pkg::SIZE_W-1:0]       r_want;
    logic [ffba_pkg::ADDR_W-1:0]       r_addr;

    // Block table.
    logic                              mem_use   [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::SIZE_W-1:0]       mem_bytes [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::CNT_W-1:0]        r_count;

    // Walk pipeline.
    logic [ffba_pkg::CNT_W-1:0]        r_rd_idx;
    logic                              r_ev_valid;
    logic [ffba_pkg::IDX_W-1:0]        r_ev_idx;
    logic                              r_rd_use;
    logic [ffba_pkg::SIZE_W-1:0]       r_rd_bytes;
    logic [ffba_pkg::OFF_W-1:0]        r_off;
    logic                              r_found;
    logic [ffba_pkg::IDX_W-1:0]        r_found_idx;
    logic                              r_found_use;

    // Output register.
    logic                              r_out_valid;
    logic [ffba_pkg::ADDR_W-1:0]       r_out_addr;
    logic [ffba_pkg::STATUS_W-1:0]     r_out_status;

    // Combinational.
    logic                              issue;
    logic [ffba_pkg::ADDR_W-1:0]       cur_paddr;
    logic                              ev_hit;
    logic                              app_fits;
    logic                              n_we_use;
    logic                              n_we_bytes;
    logic [ffba_pkg::IDX_W-1:0]        n_wa;
    logic                              n_wd_use;
    logic                              n_count_inc;
    logic [ffba_pkg::ADDR_W-1:0]       n_res_addr;
    logic [ffba_pkg::STATUS_W-1:0]     n_res_status;

    assign issue     = i_cmd.walk && (r_rd_idx < r_count);
    assign cur_paddr = r_base + ffba_pkg::ADDR_W'(r_off)
                     + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);

    always_comb begin
        if (r_req_type == ffba_pkg::REQ_ALLOC) begin
            ev_hit = r_ev_valid && !r_rd_use && (r_rd_bytes >= r_want);
        end else begin
            ev_hit = r_ev_valid && (cur_paddr == r_addr);
        end
    end

    assign app_fits = (r_count < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
                   && ((ffba_pkg::CMP_W'(r_off) + ffba_pkg::CMP_W'(r_want))
                       < ffba_pkg::CMP_W'(r_size));

    assign o_sts.hit      = i_cmd.walk && ev_hit;
    assign o_sts.walk_end = !r_ev_valid && !(r_rd_idx < r_count);
    assign o_sts.out_room = !r_out_valid || !i_out_stall;

    // Outcome of the request once the walk has ended.
    always_comb begin
        n_we_use     = 1'b0;
        n_we_bytes   = 1'b0;
        n_wa         = r_found_idx;
        n_wd_use     = 1'b1;
        n_count_inc  = 1'b0;
        n_res_addr   = '0;
        n_res_status = ffba_pkg::STATUS_NOSPACE;
        if (r_req_type == ffba_pkg::REQ_ALLOC) begin
            if (r_found) begin
                n_we_use     = 1'b1;
                n_res_addr   = cur_paddr;
                n_res_status = ffba_pkg::STATUS_OK;
            end else if (app_fits) begin
                n_we_use     = 1'b1;
                n_we_bytes   = 1'b1;
                n_wa         = r_count[ffba_pkg::IDX_W-1:0];
                n_count_inc  = 1'b1;
                n_res_addr   = cur_paddr;
                n_res_status = ffba_pkg::STATUS_OK;
            end
        end else begin
            n_res_status = ffba_pkg::STATUS_BADFREE;
            if (r_found && r_found_use) begin
                n_we_use     = 1'b1;
                n_wd_use     = 1'b0;
                n_res_addr   = r_addr;
                n_res_status = ffba_pkg::STATUS_OK;
            end
        end
    end

    // Block table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && n_we_use) begin
            mem_use[n_wa] <= n_wd_use;
        end
        if (i_cmd.finish && n_we_bytes) begin
            mem_bytes[n_wa] <= r_want;
        end
        r_rd_use   <= mem_use[r_rd_idx[ffba_pkg::IDX_W-1:0]];
        r_rd_bytes <= mem_bytes[r_rd_idx[ffba_pkg::IDX_W-1:0]];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_size      <= ffba_pkg::HEAP_SIZE_W'(1 << ffba_pkg::SIZE_W);
            r_count     <= '0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ffba_pkg::CFG_HEAP_BASE: r_base <= i_cfg_data;
                    ffba_pkg::CFG_HEAP_SIZE: r_size <= i_cfg_data[ffba_pkg::HEAP_SIZE_W-1:0];
                    default: r_base <= r_base;
                endcase
            end
            if (i_cmd.finish && n_count_inc) begin
                r_count <= r_count + ffba_pkg::CNT_W'(1);
            end
            r_ev_valid <= issue;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_want     <= i_request_size;
            r_addr     <= i_free_address;
            r_rd_idx   <= '0;
            r_off      <= '0;
            r_found    <= 1'b0;
        end else begin
            if (issue) begin
                r_rd_idx <= r_rd_idx + ffba_pkg::CNT_W'(1);
            end
            if (i_cmd.walk && r_ev_valid) begin
                if (ev_hit) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_ev_idx;
                    r_found_use <= r_rd_use;
                end else begin
                    r_off <= r_off + ffba_pkg::OFF_W'(ffba_pkg::HEADER_BYTES)
                           + ffba_pkg::OFF_W'(r_rd_bytes);
                end
            end
        end
        r_ev_idx <= r_rd_idx[ffba_pkg::IDX_W-1:0];
        if (i_cmd.finish) begin
            r_out_addr   <= n_res_addr;
            r_out_status <= n_res_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_address = r_out_addr;
    assign o_status          = r_out_status;

endmodule

`default_nettype wire

// ===== hdl/first_fit_block_allocator_unit.sv =====
// Top level of the first-fit block allocator.
// Instantiates ffba_ctrl and ffba_dp; uses types from ffba_pkg.
`default_nettype none

// The block serves allocate and free requests against a heap whose blocks
// are kept in an on-chip table of in-use flags and payload sizes.
// Requests arrive on the input channel (i_in_valid, o_in_stall); a transfer
// takes place on a rising edge with valid high and stall low. Each request
// yields exactly one result on the output channel (o_out_valid, i_out_stall)
// carrying the payload address and a status code.
// A request walks the table one entry per cycle through its single read
// port, from the first entry up to the last entry in the table; an allocate
// that reuses entry k, or a free that finds entry k, ends its walk at that
// entry. With the receiver ready, the input is open again in the same cycle
// as the result is presented.
// One request is in progress at a time. The input is taken again as soon as
// the result has been placed in the output register, even while that result
// still waits on a stalled receiver; a second result then waits in the
// datapath until the output register has been emptied.
// Synchronous reset (i_rst_n low) empties the table, clears any pending
// result, and sets the heap base to zero and the heap size to 16 MiB.
// The configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data, and should be written only while the block is idle.

module first_fit_block_allocator_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ffba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ffba_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_req_type,
    input  wire logic [ffba_pkg::SIZE_W-1:0]        i_request_size,
    input  wire logic [ffba_pkg::ADDR_W-1:0]        i_free_address,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]             o_payload_address,
    output logic [ffba_pkg::STATUS_W-1:0]           o_status
);

    ffba_pkg::t_dp_cmd dp_cmd;
    ffba_pkg::t_dp_sts dp_sts;

    // Sequencing of load, table walk and result write-back.
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Table, offset accumulation, address compare and output register.
    ffba_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_request_size    (i_request_size),
        .i_free_address    (i_free_address),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_payload_address (o_payload_address),
        .o_status          (o_status),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts)
    );

endmodule

`default_nettype wire

// ===== hdl/ffba_chk.sv =====
// Port-level checker of the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_unit.
`default_nettype none

module ffba_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [ffba_pkg::ADDR_W-1:0]     o_payload_address,
    input wire logic [ffba_pkg::STATUS_W-1:0]   o_status
);

    // A presented result carries one of the defined status codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ffba_pkg::STATUS_OK
                      || o_status == ffba_pkg::STATUS_NOSPACE
                      || o_status == ffba_pkg::STATUS_BADFREE))
        else $error("result with undefined status code");

    // A failed request reports a zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ffba_pkg::STATUS_OK) |-> (o_payload_address == '0))
        else $error("failed request with non-zero address");

    // A request is walked alone: the input is busy in the cycle after a transfer.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again directly after a transfer");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_payload_address) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind first_fit_block_allocator_unit ffba_chk u_ffba_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_payload_address (o_payload_address),
    .o_status          (o_status)
);

`default_nettype wire
